[rtl/pdi_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdi_pkg
// Shared types, codes and helpers of the profile depth interpolator.
// ----------------------------------------------------------------------------
package pdi_pkg;

  // Default number of breakpoints in the table.
  localparam int POINTS_DEF = 16;

  // Field widths.
  localparam int Q_W    = 24;
  localparam int STEP_W = 16;
  localparam int IDX_W  = 4;
  localparam int SUM_W  = 52;

  // Configuration port geometry.
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  // Register indexes, taken from the word address bits of paddr.
  localparam logic REG_PROFILE_MODE = 1'b0;

  // Item function codes.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef logic signed [Q_W-1:0] q_t;

  // Depth constants in Q15.8 metres.
  localparam q_t ONE_METRE  = q_t'(256);
  localparam q_t SWEEP_HIGH = q_t'(3840);
  localparam q_t SWEEP_LOW  = q_t'(1280);

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] point_index;
    q_t               point_dist;
    q_t               point_depth;
    logic             direction_up;
    q_t               travel_dist;
    q_t               togo_dist;
    logic [STEP_W-1:0] sweep_step;
    q_t               depth_in_first;
    q_t               depth_in_second;
  } in_word_t;

  typedef struct packed {
    q_t depth_first;
    q_t depth_second;
  } out_word_t;

  // One breakpoint as held in the table memory.
  typedef struct packed {
    q_t distance;
    q_t depth;
  } pt_t;

  // Saturate a wide signed value to the Q15.8 range.
  function automatic q_t sat_q(input logic signed [SUM_W-1:0] v);
    q_t r;
    if ((v[SUM_W-1:Q_W-1] == '0) || (v[SUM_W-1:Q_W-1] == '1)) begin
      r = v[Q_W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(Q_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

[rtl/pdi_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdi_in_if
// Valid/ready channel that carries input words to the interpolator.
// ----------------------------------------------------------------------------
interface pdi_in_if;
  import pdi_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/pdi_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdi_out_if
// Valid/ready channel that carries result words from the interpolator.
// ----------------------------------------------------------------------------
interface pdi_out_if;
  import pdi_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/profile_depth_interpolator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// profile_depth_interpolator
// Breakpoint table depth generator with a linear interpolator and a sweep.
// ----------------------------------------------------------------------------
// Usage:
// Words arrive on in_ch and results leave on out_ch, one result word for each
// input word, in order. A point write (func 0) stores one breakpoint in the
// table memory and answers 0, 0. A query (func 1) answers two new depths,
// either from the table (profile_mode_on set over the APB port) or by moving
// the supplied depths one step up or down (sweep).
// Point writes and sweep queries load their result into the output register
// at the edge that takes the word. A profile query reads entry 0, then scans
// the table one entry per cycle, then passes through a multiply step, a
// divider load step, the bit-serial divider and a final step. A zero-length
// segment skips the divider. The block works on one word at a time;
// in_ch.ready is high when it is free and the output register is empty or
// being emptied.
// Reset clears the mode register to sweep, the sweep direction to rising and
// drops any pending result; the table content is kept and is undefined until
// written. A stalled receiver holds the result; a profile query then waits
// in its final cycle and no new word is taken.
// ----------------------------------------------------------------------------
module profile_depth_interpolator #(
  parameter int POINTS = pdi_pkg::POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pdi_pkg::CFG_AW-1:0] paddr,
  input  logic [pdi_pkg::CFG_DW-1:0] pwdata,
  output logic [pdi_pkg::CFG_DW-1:0] prdata,
  output logic                      pready,
  pdi_in_if.sink                    in_ch,
  pdi_out_if.source                 out_ch
);
  import pdi_pkg::*;

  localparam int IW       = $clog2(POINTS);
  localparam int SEG_LAST = POINTS - 2;
  localparam int QW       = 50;
  localparam int DW       = 24;
  localparam int CNT_W    = $clog2(QW);
  localparam int PROD_W   = 51;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD0  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_LOAD = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0]  state;
  logic        profile_mode_on;
  logic        sweep_rising;

  // Table memory and its read port.
  pt_t         mem [POINTS];
  pt_t         rdata;
  logic [IW-1:0] rd_addr;

  // Scan and arithmetic registers.
  logic [IW-1:0]             seg;
  pt_t                       cur;
  q_t                        dist0;
  q_t                        pos;
  logic                      up;
  logic signed [24:0]        span;
  logic signed [24:0]        rise;
  logic signed [25:0]        offs;
  logic signed [PROD_W-1:0]  prod;
  logic [QW-1:0]             divn;
  logic [DW-1:0]             divd;
  logic [DW-1:0]             rem;
  logic [CNT_W-1:0]          cnt;
  logic                      neg;
  logic                      zero_span;

  // Output register.
  logic      out_valid;
  out_word_t out_data;

  logic      out_free;
  logic      acc;
  logic      load_out;
  out_word_t res;

  logic signed [24:0]        span_c;
  logic signed [24:0]        rise_c;
  logic signed [25:0]        offs_c;
  logic                      beyond;
  logic                      advance;
  logic signed [PROD_W-1:0]  prod_abs;
  logic signed [24:0]        span_abs;
  logic [DW:0]               r2;
  logic                      ge;
  logic signed [PROD_W-1:0]  quot;
  logic signed [SUM_W-1:0]   d_sum;
  logic signed [16:0]        step_s;
  logic signed [25:0]        sw_first;
  logic signed [25:0]        sw_second;
  q_t                        sw_first_sat;
  q_t                        sw_second_sat;
  logic                      idx_ok;
  logic                      cfg_wr;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[CFG_AW-1] == REG_PROFILE_MODE) ? CFG_DW'(profile_mode_on) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      profile_mode_on <= 1'b0;
    end else if (cfg_wr && (paddr[CFG_AW-1] == REG_PROFILE_MODE)) begin
      profile_mode_on <= pwdata[0];
    end
  end

  // Handshake.
  assign out_free    = !out_valid || out_ch.ready;
  assign in_ch.ready = (state == S_IDLE) && out_free;
  assign acc         = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  // Table write and synchronous (registered) read.
  assign idx_ok = 32'(in_ch.data.point_index) < POINTS;

  always_ff @(posedge clk) begin
    if (acc && (in_ch.data.func == FUNC_WRITE) && idx_ok) begin
      mem[IW'(in_ch.data.point_index)] <= {in_ch.data.point_dist, in_ch.data.point_depth};
    end
    rdata <= mem[rd_addr];
  end

  // Read address: entry 0 on a query, then the point after the next one.
  always_comb begin
    case (state)
      S_IDLE:  rd_addr = '0;
      S_RD0:   rd_addr = IW'(1);
      S_SCAN:  rd_addr = seg + IW'(2);
      default: rd_addr = '0;
    endcase
  end

  // Segment test and the segment quantities from the current pair.
  assign beyond  = up ? (pos > rdata.distance) : (pos < rdata.distance);
  assign advance = (32'(seg) < SEG_LAST) && beyond;
  assign span_c  = 25'(rdata.distance) - 25'(cur.distance);
  assign rise_c  = 25'(rdata.depth) - 25'(cur.depth);
  assign offs_c  = up ? (26'(pos) - 26'(cur.distance))
                      : (26'(pos) - 26'(cur.distance) + 26'(dist0));

  // Divider operands in magnitude form.
  assign prod_abs = prod[PROD_W-1] ? -prod : prod;
  assign span_abs = span[24] ? -span : span;
  assign r2       = {rem, divn[QW-1]};
  assign ge       = r2 >= {1'b0, divd};

  // Final depth from the signed quotient and the segment start depth; zero for a zero-length segment.
  assign quot  = neg ? -PROD_W'({1'b0, divn}) : PROD_W'({1'b0, divn});
  assign d_sum = zero_span ? '0 : (SUM_W'(quot) + SUM_W'(cur.depth));

  // Sweep arithmetic.
  assign step_s        = sweep_rising ? $signed({1'b0, in_ch.data.sweep_step})
                                      : -$signed({1'b0, in_ch.data.sweep_step});
  assign sw_first      = 26'(in_ch.data.depth_in_first) + 26'(step_s);
  assign sw_second     = 26'(in_ch.data.depth_in_second) + 26'(step_s);
  assign sw_first_sat  = sat_q(SUM_W'(sw_first));
  assign sw_second_sat = sat_q(SUM_W'(sw_second));

  // Result selection.
  always_comb begin
    load_out = 1'b0;
    res      = '0;
    if (state == S_FIN) begin
      load_out = out_free;
      res.depth_first  = sat_q(d_sum);
      res.depth_second = sat_q(d_sum + SUM_W'(ONE_METRE));
    end else if (acc) begin
      if (in_ch.data.func == FUNC_WRITE) begin
        load_out = 1'b1;
      end else if (!profile_mode_on) begin
        load_out = 1'b1;
        res.depth_first  = sw_first_sat;
        res.depth_second = sw_second_sat;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end
    end
    if (load_out) begin
      out_data <= res;
    end
  end

  // Sweep direction.
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_rising <= 1'b1;
    end else if (acc && (in_ch.data.func == FUNC_QUERY) && !profile_mode_on) begin
      if ((sw_first_sat > SWEEP_HIGH) || (sw_first_sat < SWEEP_LOW)) begin
        sweep_rising <= !sweep_rising;
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (acc && (in_ch.data.func == FUNC_QUERY) && profile_mode_on) begin
            state <= S_RD0;
          end
        end
        S_RD0:  state <= S_SCAN;
        S_SCAN: begin
          if (!advance) begin
            state <= S_MUL;
          end
        end
        S_MUL:  state <= S_LOAD;
        S_LOAD: state <= (span == '0) ? S_FIN : S_DIV;
        S_DIV: begin
          if (cnt == '0) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        up  <= in_ch.data.direction_up;
        pos <= in_ch.data.direction_up ? in_ch.data.travel_dist : in_ch.data.togo_dist;
        seg <= '0;
      end
      S_RD0: begin
        cur   <= rdata;
        dist0 <= rdata.distance;
      end
      S_SCAN: begin
        if (advance) begin
          cur <= rdata;
          seg <= seg + IW'(1);
        end else begin
          span <= span_c;
          rise <= rise_c;
          offs <= offs_c;
        end
      end
      S_MUL: begin
        prod <= PROD_W'(rise) * PROD_W'(offs);
      end
      S_LOAD: begin
        divn      <= prod_abs[QW-1:0];
        divd      <= span_abs[DW-1:0];
        neg       <= prod[PROD_W-1] ^ span[24];
        rem       <= '0;
        cnt       <= CNT_W'(QW - 1);
        zero_span <= (span == '0);
      end
      S_DIV: begin
        if (ge) begin
          rem <= DW'(r2 - {1'b0, divd});
        end else begin
          rem <= r2[DW-1:0];
        end
        divn <= {divn[QW-2:0], ge};
        cnt  <= cnt - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Checks.
  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (32'(seg) <= SEG_LAST))
    else $error("segment index ran past the last segment");

  a_query_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (acc && (in_ch.data.func == FUNC_QUERY) && profile_mode_on) |=> (state == S_RD0))
    else $error("profile query did not start a table read");

  a_write_answers: assert property (@(posedge clk) disable iff (rst)
    (acc && (in_ch.data.func == FUNC_WRITE)) |=> (out_valid && (out_data == '0)))
    else $error("point write did not answer zero depths");

  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DIV) && (cnt == '0)) |=> (state == S_FIN))
    else $error("divider did not hand over to the final cycle");

  a_sweep_dir: assert property (@(posedge clk) disable iff (rst)
    (!$stable(sweep_rising) && !$past(rst)) |->
      $past(acc && (in_ch.data.func == FUNC_QUERY) && !profile_mode_on))
    else $error("sweep direction changed without a sweep query");

endmodule
